/* rtl/msp_pkg.sv */
// msp_pkg: shared types, codes and sizes of the looped macro step player
// used by the controller, the top level and the port checker; no dependencies

package msp_pkg;

  localparam int STEP_DEPTH = 1024;
  localparam int ADDR_W     = $clog2(STEP_DEPTH);
  localparam int PTR_W      = 11;
  localparam int LOOP_W     = 32;
  localparam int TICK_W     = 32;
  localparam int BTN_W      = 64;
  localparam int STICK_W    = 16;
  localparam int IDX_W      = 10;
  localparam int CFG_W      = 32;
  localparam int IN_DATA_W  = 208;
  localparam int OUT_DATA_W = 176;

  // step entry layout in the step memory
  localparam int ENTRY_W   = 192;
  localparam int E_BTN_LO  = 0;
  localparam int E_STK_LO  = 64;
  localparam int E_REL_LO  = 128;
  localparam int E_HOLD_LO = 160;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_STOP  = 2'd2;
  localparam logic [1:0] OP_TICK  = 2'd3;

  localparam logic CFG_STEP_COUNT = 1'b0;
  localparam logic CFG_LOOP_LIMIT = 1'b1;

  localparam logic [PTR_W-1:0]  STEP_COUNT_RST = 11'd1;
  localparam logic [LOOP_W-1:0] LOOP_LIMIT_RST = '0;

  typedef struct packed {
    logic [BTN_W-1:0]   buttons;
    logic [4*STICK_W-1:0] sticks;
    logic               playing;
    logic [LOOP_W-1:0]  loops;
    logic [PTR_W-1:0]   position;
  } res_t;

  // zero acts as one, anything above the memory depth acts as the depth
  function automatic logic [PTR_W-1:0] valid_steps(input logic [PTR_W-1:0] sc);
    logic [PTR_W-1:0] n;
    n = sc;
    if (sc == '0) n = PTR_W'(1);
    if (sc > PTR_W'(STEP_DEPTH)) n = PTR_W'(STEP_DEPTH);
    return n;
  endfunction

endpackage

/* rtl/msp_ram.sv */
// msp_ram: generic single-port synchronous ram with registered read data
// no dependencies; read data holds until the next read

module msp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/msp_ctrl.sv */
// msp_ctrl: item sequencer of the step player; holds config, play state and
// drives the step memory. depends on msp_pkg and msp_ram

module msp_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [msp_pkg::CFG_W-1:0]  cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 in_op_i,
  input  logic [msp_pkg::IDX_W-1:0]  in_idx_i,
  input  logic [msp_pkg::ENTRY_W-1:0] in_entry_i,
  output logic                       res_valid_o,
  input  logic                       res_ready_i,
  output msp_pkg::res_t              res_o
);
  import msp_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_LOAD = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [1:0]        op_q;
  logic [IDX_W-1:0]  idx_q;
  logic [ENTRY_W-1:0] entry_q;

  logic              play_q, play_d;
  logic              rel_q, rel_d;
  logic [TICK_W-1:0] ticks_q, ticks_d;
  logic [PTR_W-1:0]  ptr_q, ptr_d;
  logic [LOOP_W-1:0] loop_q, loop_d;
  logic [PTR_W-1:0]  step_count_q;
  logic [LOOP_W-1:0] loop_limit_q;

  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_addr;
  logic [ENTRY_W-1:0] ram_rdata;

  logic [TICK_W-1:0] tick_dec;
  logic [TICK_W-1:0] cur_rel, cur_hold;
  logic [PTR_W-1:0]  next_ptr;
  logic [LOOP_W-1:0] next_loop;

  msp_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(STEP_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .re_i   (ram_re),
    .addr_i (ram_addr),
    .wdata_i(entry_q),
    .rdata_o(ram_rdata)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);

  // read data holds the entry at the step pointer while playing
  assign cur_rel   = ram_rdata[E_REL_LO +: TICK_W];
  assign cur_hold  = ram_rdata[E_HOLD_LO +: TICK_W];
  assign tick_dec  = (ticks_q != '0) ? ticks_q - TICK_W'(1) : '0;
  assign next_ptr  = ptr_q + PTR_W'(1);
  assign next_loop = loop_q + LOOP_W'(1);

  always_comb begin
    state_d  = state_q;
    play_d   = play_q;
    rel_d    = rel_q;
    ticks_d  = ticks_q;
    ptr_d    = ptr_q;
    loop_d   = loop_q;
    ram_we   = 1'b0;
    ram_re   = 1'b0;
    ram_addr = ADDR_W'(idx_q);
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = S_DONE;
        case (op_q)
          OP_WRITE: begin
            ram_we = !play_q && ({1'b0, idx_q} < (IDX_W+1)'(STEP_DEPTH));
          end
          OP_START: begin
            play_d   = 1'b1;
            loop_d   = '0;
            ptr_d    = '0;
            ram_re   = 1'b1;
            ram_addr = '0;
            state_d  = S_LOAD;
          end
          OP_STOP: begin
            if (play_q) begin
              play_d  = 1'b0;
              rel_d   = 1'b0;
              ticks_d = '0;
            end
          end
          default: begin
            if (play_q) begin
              if (tick_dec != '0) begin
                ticks_d = tick_dec;
              end else if (!rel_q && cur_rel != '0) begin
                rel_d   = 1'b1;
                ticks_d = cur_rel;
              end else if (next_ptr >= valid_steps(step_count_q)) begin
                // end of the list: count the loop, stop or wrap
                loop_d = next_loop;
                if (loop_limit_q != '0 && next_loop >= loop_limit_q) begin
                  play_d  = 1'b0;
                  rel_d   = 1'b0;
                  ticks_d = '0;
                  ptr_d   = next_ptr;
                end else begin
                  ptr_d    = '0;
                  ram_re   = 1'b1;
                  ram_addr = '0;
                  state_d  = S_LOAD;
                end
              end else begin
                ptr_d    = next_ptr;
                ram_re   = 1'b1;
                ram_addr = (next_ptr < PTR_W'(STEP_DEPTH)) ? ADDR_W'(next_ptr) : '0;
                state_d  = S_LOAD;
              end
            end
          end
        endcase
      end
      S_LOAD: begin
        rel_d   = 1'b0;
        ticks_d = (cur_hold == '0) ? TICK_W'(1) : cur_hold;
        state_d = S_DONE;
      end
      default: begin
        if (res_ready_i) state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    res_o.buttons  = '0;
    res_o.sticks   = '0;
    if (play_q && !rel_q) begin
      res_o.buttons = ram_rdata[E_BTN_LO +: BTN_W];
      res_o.sticks  = ram_rdata[E_STK_LO +: 4*STICK_W];
    end
    res_o.playing  = play_q;
    res_o.loops    = loop_q;
    res_o.position = ptr_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      play_q       <= 1'b0;
      rel_q        <= 1'b0;
      ticks_q      <= '0;
      ptr_q        <= '0;
      loop_q       <= '0;
      step_count_q <= STEP_COUNT_RST;
      loop_limit_q <= LOOP_LIMIT_RST;
    end else begin
      state_q <= state_d;
      play_q  <= play_d;
      rel_q   <= rel_d;
      ticks_q <= ticks_d;
      ptr_q   <= ptr_d;
      loop_q  <= loop_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_STEP_COUNT: step_count_q <= cfg_wdata_i[PTR_W-1:0];
          CFG_LOOP_LIMIT: loop_limit_q <= cfg_wdata_i[LOOP_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_q    <= in_op_i;
      idx_q   <= in_idx_i;
      entry_q <= in_entry_i;
    end
  end

endmodule

/* rtl/looped_macro_step_player_top.sv */
// looped_macro_step_player_top: stream wrapper, field packing and output
// register around msp_ctrl. depends on msp_pkg, msp_ctrl and msp_ram
//
// The player takes one item at a time: an item passes S_EXEC and S_DONE,
// plus S_LOAD when it starts play or advances to another step, since the
// step memory (one 192-bit entry per step, single port, registered read)
// is read then. The result waits in an output register and the next item
// is taken while it is still pending. Step entries are written with write
// items while stopped; only written entries may be played. Each item gives
// exactly one result showing what the pad drives after it.

module looped_macro_step_player_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [msp_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // operation, entry_index, button_mask, left_x, left_y, right_x, right_y,
  // hold_ticks, release_ticks, zero fill
  input  logic [msp_pkg::IN_DATA_W-1:0] s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // pad_buttons, pad_left_x, pad_left_y, pad_right_x, pad_right_y, playing,
  // loops_done, step_position, zero fill
  output logic [msp_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import msp_pkg::*;

  logic              res_valid, res_ready;
  res_t              res;
  res_t              out_q;
  logic              out_valid_q;
  logic [ENTRY_W-1:0] in_entry;

  // step memory entry: buttons, sticks, release, hold from bit 0 up
  assign in_entry = {s_axis_tdata[140 +: TICK_W],
                     s_axis_tdata[172 +: TICK_W],
                     s_axis_tdata[76 +: 4*STICK_W],
                     s_axis_tdata[12 +: BTN_W]};

  msp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_op_i    (s_axis_tdata[1:0]),
    .in_idx_i   (s_axis_tdata[2 +: IDX_W]),
    .in_entry_i (in_entry),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res)
  );

  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0, out_q.position, out_q.loops, out_q.playing,
                          out_q.sticks, out_q.buttons};

endmodule

/* rtl/msp_checker.sv */
// msp_checker: port-level checks of the step player, bound to the top level
// depends on msp_pkg

module msp_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [msp_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import msp_pkg::*;

  // a pending result is not dropped
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // one item at a time: no item is taken right after another
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("item accepted back to back");

  // stopped pad drives nothing
  a_idle_released: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[128] |-> m_axis_tdata[127:0] == '0)
    else $error("pad driven while stopped");

  // step position never passes the memory depth
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[171:161] <= PTR_W'(STEP_DEPTH))
    else $error("step position out of range");

endmodule

bind looped_macro_step_player_top msp_checker u_msp_checker (.*);
